// ===== src/c6502eu_pkg.sv =====
// ============================================================================
// c6502eu_pkg
// Shared types and constants for the 6502 data-operation execute unit.
// ============================================================================
package c6502eu_pkg;

    localparam int KIND_W   = 6;
    localparam int BYTE_W   = 8;

    // Stream payload layout
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 1;

    // Status byte bit positions, NV1BDIZC
    localparam int FLAG_C = 0;
    localparam int FLAG_Z = 1;
    localparam int FLAG_I = 2;
    localparam int FLAG_D = 3;
    localparam int FLAG_V = 6;
    localparam int FLAG_N = 7;

    localparam logic [BYTE_W-1:0] SIGN_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] OVFL_MASK = 8'h40;
    localparam logic [BYTE_W-1:0] SP_RESET  = 8'hFD;
    localparam logic [BYTE_W-1:0] P_RESET   = 8'h24;

    typedef enum logic [KIND_W-1:0] {
        K_ADC = 6'd0,  K_SBC = 6'd1,  K_AND = 6'd2,  K_ORA = 6'd3,
        K_EOR = 6'd4,  K_ASL = 6'd5,  K_LSR = 6'd6,  K_ROL = 6'd7,
        K_ROR = 6'd8,  K_INC = 6'd9,  K_DEC = 6'd10, K_INX = 6'd11,
        K_INY = 6'd12, K_DEX = 6'd13, K_DEY = 6'd14, K_CMP = 6'd15,
        K_CPX = 6'd16, K_CPY = 6'd17, K_BIT = 6'd18, K_LDA = 6'd19,
        K_LDX = 6'd20, K_LDY = 6'd21, K_LAX = 6'd22, K_STA = 6'd23,
        K_STX = 6'd24, K_STY = 6'd25, K_SAX = 6'd26, K_TAX = 6'd27,
        K_TAY = 6'd28, K_TXA = 6'd29, K_TYA = 6'd30, K_TSX = 6'd31,
        K_TXS = 6'd32, K_CLC = 6'd33, K_SEC = 6'd34, K_CLD = 6'd35,
        K_SED = 6'd36, K_CLI = 6'd37, K_SEI = 6'd38, K_CLV = 6'd39,
        K_DCP = 6'd40, K_ISB = 6'd41, K_SLO = 6'd42, K_RLA = 6'd43,
        K_SRE = 6'd44, K_RRA = 6'd45
    } t_kind;

endpackage

// ===== src/cpu6502_execute_unit.sv =====
// ============================================================================
// cpu6502_execute_unit
// Executes one decoded 6502 data operation per item on the kept A, X, Y, SP
// and status registers and reports the memory write-back and all registers.
// ============================================================================
// The unit takes one item per clock cycle while the output side is not
// stalled and returns one result for each item via the input register and
// then the result register. The 8-bit ALU, shifter and compare logic work
// combinationally on the item and on the architectural registers, and the
// result register and the registers A, X, Y, SP and P load at the same edge,
// so the following item already sees the updated state. The input side keeps
// accepting while a result waits, as long as the input register is empty or
// can move on at the same edge. Arithmetic is binary only; the D flag is
// kept but never used. Kind codes 46 to 63 leave every register untouched
// and write nothing. Status bits 4 and 5 are never changed (0x24 after reset).
module cpu6502_execute_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input items
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // [5:0] kind, [13:6] operand_value, [15:14] zero
    input  logic [0:0]  i_s_axis_tuser,  // [0] to_accumulator
    // result items
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,  // [7:0] store_value, [15:8] acc_out,
                                         // [23:16] index_x_out, [31:24] index_y_out,
                                         // [39:32] stack_ptr_out, [47:40] status_out
    output logic [0:0]  o_m_axis_tuser   // [0] store_enable
);

    localparam int BW = c6502eu_pkg::BYTE_W;

    // Input register
    logic                              r_in_valid;
    logic [c6502eu_pkg::KIND_W-1:0]    r_kind;
    logic [BW-1:0]                     r_opnd;
    logic                              r_to_acc;

    // Architectural registers
    logic [BW-1:0] r_a, r_x, r_y, r_sp, r_p;
    logic [BW-1:0] n_a, n_x, n_y, n_sp, n_p;

    // Result register
    logic          r_out_valid;
    logic          r_st_en;
    logic [BW-1:0] r_st_val, r_out_a, r_out_x, r_out_y, r_out_sp, r_out_p;
    logic          n_st_en;
    logic [BW-1:0] n_st_val;

    logic advance;
    logic s_fire;

    // Datapath helpers
    logic          cin;
    logic [BW-1:0] sh_src, sh_asl, sh_lsr, sh_rol, sh_ror;
    logic [BW-1:0] m_inc, m_dec, m_ror;
    logic [BW-1:0] add_b;
    logic          add_ci;
    logic [BW:0]   add_sum;
    logic [BW-1:0] add_r;
    logic          add_v;
    logic [BW-1:0] cmp_reg, cmp_m;
    logic [BW:0]   cmp_diff;

    // Move the input register on whenever the result register is free or
    // being emptied at this edge.
    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_kind   <= i_s_axis_tdata[5:0];
            r_opnd   <= i_s_axis_tdata[13:6];
            r_to_acc <= i_s_axis_tuser[0];
        end
    end

    // Shifter and memory-operand variants
    assign cin    = r_p[c6502eu_pkg::FLAG_C];
    assign sh_src = r_to_acc ? r_a : r_opnd;
    assign sh_asl = {sh_src[BW-2:0], 1'b0};
    assign sh_lsr = {1'b0, sh_src[BW-1:1]};
    assign sh_rol = {sh_src[BW-2:0], cin};
    assign sh_ror = {cin, sh_src[BW-1:1]};
    assign m_inc  = r_opnd + 8'd1;
    assign m_dec  = r_opnd - 8'd1;
    assign m_ror  = {cin, r_opnd[BW-1:1]};

    // Adder operand select: ADC, SBC, ISB and RRA share one 8-bit adder
    always_comb begin
        add_b  = r_opnd;
        add_ci = cin;
        case (r_kind)
            c6502eu_pkg::K_SBC: add_b = ~r_opnd;
            c6502eu_pkg::K_ISB: add_b = ~m_inc;
            c6502eu_pkg::K_RRA: begin
                add_b  = m_ror;
                add_ci = r_opnd[0];
            end
            default: add_b = r_opnd;
        endcase
    end

    assign add_sum = {1'b0, r_a} + {1'b0, add_b} + {{BW{1'b0}}, add_ci};
    assign add_r   = add_sum[BW-1:0];
    assign add_v   = ((add_b ^ add_r) & (r_a ^ add_r) & c6502eu_pkg::SIGN_MASK) != '0;

    // Compare operand select: CMP, CPX, CPY and DCP share one subtractor
    always_comb begin
        cmp_reg = r_a;
        cmp_m   = r_opnd;
        case (r_kind)
            c6502eu_pkg::K_CPX: cmp_reg = r_x;
            c6502eu_pkg::K_CPY: cmp_reg = r_y;
            c6502eu_pkg::K_DCP: cmp_m   = m_dec;
            default:            cmp_reg = r_a;
        endcase
    end

    assign cmp_diff = {1'b0, cmp_reg} - {1'b0, cmp_m};

    // Next register values for the item in the input register
    always_comb begin
        logic          zn_en;
        logic [BW-1:0] zn_val;
        logic          add_en;
        logic          cmp_en;
        zn_en    = 1'b0;
        zn_val   = '0;
        add_en   = 1'b0;
        cmp_en   = 1'b0;
        n_a      = r_a;
        n_x      = r_x;
        n_y      = r_y;
        n_sp     = r_sp;
        n_p      = r_p;
        n_st_en  = 1'b0;
        n_st_val = '0;
        case (r_kind)
            c6502eu_pkg::K_ADC, c6502eu_pkg::K_SBC: add_en = 1'b1;
            c6502eu_pkg::K_AND: begin
                n_a = r_a & r_opnd; zn_en = 1'b1; zn_val = n_a;
            end
            c6502eu_pkg::K_ORA: begin
                n_a = r_a | r_opnd; zn_en = 1'b1; zn_val = n_a;
            end
            c6502eu_pkg::K_EOR: begin
                n_a = r_a ^ r_opnd; zn_en = 1'b1; zn_val = n_a;
            end
            c6502eu_pkg::K_ASL, c6502eu_pkg::K_LSR,
            c6502eu_pkg::K_ROL, c6502eu_pkg::K_ROR: begin
                case (r_kind)
                    c6502eu_pkg::K_ASL: zn_val = sh_asl;
                    c6502eu_pkg::K_LSR: zn_val = sh_lsr;
                    c6502eu_pkg::K_ROL: zn_val = sh_rol;
                    default:            zn_val = sh_ror;
                endcase
                zn_en = 1'b1;
                if (r_kind == c6502eu_pkg::K_ASL || r_kind == c6502eu_pkg::K_ROL) begin
                    n_p[c6502eu_pkg::FLAG_C] = sh_src[BW-1];
                end else begin
                    n_p[c6502eu_pkg::FLAG_C] = sh_src[0];
                end
                if (r_to_acc) begin
                    n_a = zn_val;
                end else begin
                    n_st_en  = 1'b1;
                    n_st_val = zn_val;
                end
            end
            c6502eu_pkg::K_INC: begin
                n_st_en = 1'b1; n_st_val = m_inc; zn_en = 1'b1; zn_val = m_inc;
            end
            c6502eu_pkg::K_DEC: begin
                n_st_en = 1'b1; n_st_val = m_dec; zn_en = 1'b1; zn_val = m_dec;
            end
            c6502eu_pkg::K_INX: begin
                n_x = r_x + 8'd1; zn_en = 1'b1; zn_val = n_x;
            end
            c6502eu_pkg::K_INY: begin
                n_y = r_y + 8'd1; zn_en = 1'b1; zn_val = n_y;
            end
            c6502eu_pkg::K_DEX: begin
                n_x = r_x - 8'd1; zn_en = 1'b1; zn_val = n_x;
            end
            c6502eu_pkg::K_DEY: begin
                n_y = r_y - 8'd1; zn_en = 1'b1; zn_val = n_y;
            end
            c6502eu_pkg::K_CMP, c6502eu_pkg::K_CPX, c6502eu_pkg::K_CPY: cmp_en = 1'b1;
            c6502eu_pkg::K_BIT: begin
                n_p[c6502eu_pkg::FLAG_Z] = (r_a & r_opnd) == '0;
                n_p[c6502eu_pkg::FLAG_V] = (r_opnd & c6502eu_pkg::OVFL_MASK) != '0;
                n_p[c6502eu_pkg::FLAG_N] = r_opnd[BW-1];
            end
            c6502eu_pkg::K_LDA: begin
                n_a = r_opnd; zn_en = 1'b1; zn_val = r_opnd;
            end
            c6502eu_pkg::K_LDX: begin
                n_x = r_opnd; zn_en = 1'b1; zn_val = r_opnd;
            end
            c6502eu_pkg::K_LDY: begin
                n_y = r_opnd; zn_en = 1'b1; zn_val = r_opnd;
            end
            c6502eu_pkg::K_LAX: begin
                n_a = r_opnd; n_x = r_opnd; zn_en = 1'b1; zn_val = r_opnd;
            end
            c6502eu_pkg::K_STA: begin
                n_st_en = 1'b1; n_st_val = r_a;
            end
            c6502eu_pkg::K_STX: begin
                n_st_en = 1'b1; n_st_val = r_x;
            end
            c6502eu_pkg::K_STY: begin
                n_st_en = 1'b1; n_st_val = r_y;
            end
            c6502eu_pkg::K_SAX: begin
                n_st_en = 1'b1; n_st_val = r_a & r_x;
            end
            c6502eu_pkg::K_TAX: begin
                n_x = r_a; zn_en = 1'b1; zn_val = r_a;
            end
            c6502eu_pkg::K_TAY: begin
                n_y = r_a; zn_en = 1'b1; zn_val = r_a;
            end
            c6502eu_pkg::K_TXA: begin
                n_a = r_x; zn_en = 1'b1; zn_val = r_x;
            end
            c6502eu_pkg::K_TYA: begin
                n_a = r_y; zn_en = 1'b1; zn_val = r_y;
            end
            c6502eu_pkg::K_TSX: begin
                n_x = r_sp; zn_en = 1'b1; zn_val = r_sp;
            end
            c6502eu_pkg::K_TXS: n_sp = r_x;
            c6502eu_pkg::K_CLC: n_p[c6502eu_pkg::FLAG_C] = 1'b0;
            c6502eu_pkg::K_SEC: n_p[c6502eu_pkg::FLAG_C] = 1'b1;
            c6502eu_pkg::K_CLD: n_p[c6502eu_pkg::FLAG_D] = 1'b0;
            c6502eu_pkg::K_SED: n_p[c6502eu_pkg::FLAG_D] = 1'b1;
            c6502eu_pkg::K_CLI: n_p[c6502eu_pkg::FLAG_I] = 1'b0;
            c6502eu_pkg::K_SEI: n_p[c6502eu_pkg::FLAG_I] = 1'b1;
            c6502eu_pkg::K_CLV: n_p[c6502eu_pkg::FLAG_V] = 1'b0;
            c6502eu_pkg::K_DCP: begin
                n_st_en = 1'b1; n_st_val = m_dec; cmp_en = 1'b1;
            end
            c6502eu_pkg::K_ISB: begin
                n_st_en = 1'b1; n_st_val = m_inc; add_en = 1'b1;
            end
            c6502eu_pkg::K_SLO: begin
                n_st_en = 1'b1;
                n_st_val = {r_opnd[BW-2:0], 1'b0};
                n_a = r_a | n_st_val; zn_en = 1'b1; zn_val = n_a;
                n_p[c6502eu_pkg::FLAG_C] = r_opnd[BW-1];
            end
            c6502eu_pkg::K_RLA: begin
                n_st_en = 1'b1;
                n_st_val = {r_opnd[BW-2:0], cin};
                n_a = r_a & n_st_val; zn_en = 1'b1; zn_val = n_a;
                n_p[c6502eu_pkg::FLAG_C] = r_opnd[BW-1];
            end
            c6502eu_pkg::K_SRE: begin
                n_st_en = 1'b1;
                n_st_val = {1'b0, r_opnd[BW-1:1]};
                n_a = r_a ^ n_st_val; zn_en = 1'b1; zn_val = n_a;
                n_p[c6502eu_pkg::FLAG_C] = r_opnd[0];
            end
            c6502eu_pkg::K_RRA: begin
                n_st_en = 1'b1; n_st_val = m_ror; add_en = 1'b1;
            end
            default: begin
                // unused codes: hold everything
                n_st_en = 1'b0;
            end
        endcase
        // apply the shared adder result
        if (add_en) begin
            n_a = add_r;
            n_p[c6502eu_pkg::FLAG_C] = add_sum[BW];
            n_p[c6502eu_pkg::FLAG_V] = add_v;
            zn_en  = 1'b1;
            zn_val = add_r;
        end
        // apply the shared compare result
        if (cmp_en) begin
            n_p[c6502eu_pkg::FLAG_C] = !cmp_diff[BW];
            n_p[c6502eu_pkg::FLAG_Z] = cmp_reg == cmp_m;
            n_p[c6502eu_pkg::FLAG_N] = cmp_diff[BW-1];
        end
        if (zn_en) begin
            n_p[c6502eu_pkg::FLAG_Z] = zn_val == '0;
            n_p[c6502eu_pkg::FLAG_N] = zn_val[BW-1];
        end
    end

    // Architectural registers advance together with the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a  <= '0;
            r_x  <= '0;
            r_y  <= '0;
            r_sp <= c6502eu_pkg::SP_RESET;
            r_p  <= c6502eu_pkg::P_RESET;
        end else if (advance) begin
            r_a  <= n_a;
            r_x  <= n_x;
            r_y  <= n_y;
            r_sp <= n_sp;
            r_p  <= n_p;
        end
    end

    // Result register: load on advance, drop valid once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_st_en  <= n_st_en;
            r_st_val <= n_st_val;
            r_out_a  <= n_a;
            r_out_x  <= n_x;
            r_out_y  <= n_y;
            r_out_sp <= n_sp;
            r_out_p  <= n_p;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_p, r_out_sp, r_out_y, r_out_x, r_out_a, r_st_val};
    assign o_m_axis_tuser  = r_st_en;

endmodule

// ===== src/c6502eu_checker.sv =====
// ============================================================================
// c6502eu_checker
// Port-level checks for the 6502 execute unit, bound to the top level.
// ============================================================================
module c6502eu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_axis_tvalid,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic [0:0]  o_m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // no write-back means a zero store byte
    a_store_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tuser[0] |-> o_m_axis_tdata[7:0] == 8'h00)
        else $error("store byte not zero without write-back");

    // status bits 4 and 5 never move from their reset values
    a_status_fixed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[45] && !o_m_axis_tdata[44])
        else $error("status bit 4 or 5 changed");

    // a free or draining output never throttles the input
    a_no_bubble: assert property (@(posedge i_clk)
        (!o_m_axis_tvalid || i_m_axis_tready) |-> o_s_axis_tready)
        else $error("input stalled with output free");

    // an item accepted while no result is offered leads to a valid result after the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid |=> ##1 o_m_axis_tvalid)
        else $error("result missing after accepted item");

endmodule

bind cpu6502_execute_unit c6502eu_checker u_c6502eu_checker (.*);

// ===== verif/cpu6502_execute_unit_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// cpu6502_execute_unit_checker
// Watches both stream channels of the execute unit, keeps its own copy of
// A, X, Y, SP and P, predicts each result item and compares it field by field.
// ============================================================================
module cpu6502_execute_unit_checker
    import c6502eu_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // [5:0] kind, [13:6] operand_value
    input  logic [S_TUSER_W-1:0] i_s_tuser,   // [0] to_accumulator
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // [7:0] store_value .. [47:40] status_out
    input  logic [M_TUSER_W-1:0] i_m_tuser,   // [0] store_enable
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct {
        logic              store_en;
        logic [BYTE_W-1:0] store_val;
        logic [BYTE_W-1:0] acc;
        logic [BYTE_W-1:0] x;
        logic [BYTE_W-1:0] y;
        logic [BYTE_W-1:0] sp;
        logic [BYTE_W-1:0] p;
    } exec_result_t;

    exec_result_t      expected_results[$];
    logic [BYTE_W-1:0] a_reg, x_reg, y_reg, sp_reg, p_reg;

    task automatic update_zn(input logic [BYTE_W-1:0] v);
        p_reg[FLAG_Z] = (v == '0);
        p_reg[FLAG_N] = v[7];
    endtask

    // binary add with true carry out of bit 7 and two's complement overflow
    task automatic add_with_carry(input logic [BYTE_W-1:0] b, input logic cin);
        logic [BYTE_W:0]   sum;
        logic [BYTE_W-1:0] r;
        sum = {1'b0, a_reg} + {1'b0, b} + {{BYTE_W{1'b0}}, cin};
        r   = sum[BYTE_W-1:0];
        p_reg[FLAG_C] = sum[BYTE_W];
        p_reg[FLAG_V] = (((b ^ r) & (a_reg ^ r) & SIGN_MASK) != '0);
        a_reg = r;
        update_zn(r);
    endtask

    task automatic compare_reg(input logic [BYTE_W-1:0] rv, input logic [BYTE_W-1:0] m);
        logic [BYTE_W-1:0] d;
        d = rv - m;
        p_reg[FLAG_C] = (rv >= m);
        p_reg[FLAG_Z] = (rv == m);
        p_reg[FLAG_N] = d[7];
    endtask

    task automatic execute_operation(
        input  logic [KIND_W-1:0] kind,
        input  logic [BYTE_W-1:0] m,
        input  logic              to_acc,
        output exec_result_t      res
    );
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] src;
        logic              cin;
        logic              cout;
        cin = p_reg[FLAG_C];
        res.store_en  = 1'b0;
        res.store_val = '0;
        case (kind)
            K_ADC: add_with_carry(m, cin);
            K_SBC: add_with_carry(~m, cin);
            K_AND: begin a_reg = a_reg & m; update_zn(a_reg); end
            K_ORA: begin a_reg = a_reg | m; update_zn(a_reg); end
            K_EOR: begin a_reg = a_reg ^ m; update_zn(a_reg); end
            K_ASL, K_LSR, K_ROL, K_ROR: begin
                src = to_acc ? a_reg : m;
                case (kind)
                    K_ASL: begin r = {src[6:0], 1'b0}; cout = src[7]; end
                    K_LSR: begin r = {1'b0, src[7:1]}; cout = src[0]; end
                    K_ROL: begin r = {src[6:0], cin};  cout = src[7]; end
                    default: begin r = {cin, src[7:1]}; cout = src[0]; end
                endcase
                if (to_acc) begin
                    a_reg = r;
                end else begin
                    res.store_en  = 1'b1;
                    res.store_val = r;
                end
                update_zn(r);
                p_reg[FLAG_C] = cout;
            end
            K_INC: begin r = m + 8'd1; res.store_en = 1'b1; res.store_val = r; update_zn(r); end
            K_DEC: begin r = m - 8'd1; res.store_en = 1'b1; res.store_val = r; update_zn(r); end
            K_INX: begin x_reg = x_reg + 8'd1; update_zn(x_reg); end
            K_INY: begin y_reg = y_reg + 8'd1; update_zn(y_reg); end
            K_DEX: begin x_reg = x_reg - 8'd1; update_zn(x_reg); end
            K_DEY: begin y_reg = y_reg - 8'd1; update_zn(y_reg); end
            K_CMP: compare_reg(a_reg, m);
            K_CPX: compare_reg(x_reg, m);
            K_CPY: compare_reg(y_reg, m);
            K_BIT: begin
                p_reg[FLAG_Z] = ((a_reg & m) == '0);
                p_reg[FLAG_V] = ((m & OVFL_MASK) != '0);
                p_reg[FLAG_N] = ((m & SIGN_MASK) != '0);
            end
            K_LDA: begin a_reg = m; update_zn(m); end
            K_LDX: begin x_reg = m; update_zn(m); end
            K_LDY: begin y_reg = m; update_zn(m); end
            K_LAX: begin a_reg = m; x_reg = m; update_zn(m); end
            K_STA: begin res.store_en = 1'b1; res.store_val = a_reg; end
            K_STX: begin res.store_en = 1'b1; res.store_val = x_reg; end
            K_STY: begin res.store_en = 1'b1; res.store_val = y_reg; end
            K_SAX: begin res.store_en = 1'b1; res.store_val = a_reg & x_reg; end
            K_TAX: begin x_reg = a_reg;  update_zn(x_reg); end
            K_TAY: begin y_reg = a_reg;  update_zn(y_reg); end
            K_TXA: begin a_reg = x_reg;  update_zn(a_reg); end
            K_TYA: begin a_reg = y_reg;  update_zn(a_reg); end
            K_TSX: begin x_reg = sp_reg; update_zn(x_reg); end
            K_TXS: sp_reg = x_reg;
            K_CLC: p_reg[FLAG_C] = 1'b0;
            K_SEC: p_reg[FLAG_C] = 1'b1;
            K_CLD: p_reg[FLAG_D] = 1'b0;
            K_SED: p_reg[FLAG_D] = 1'b1;
            K_CLI: p_reg[FLAG_I] = 1'b0;
            K_SEI: p_reg[FLAG_I] = 1'b1;
            K_CLV: p_reg[FLAG_V] = 1'b0;
            K_DCP: begin
                r = m - 8'd1; res.store_en = 1'b1; res.store_val = r;
                compare_reg(a_reg, r);
            end
            K_ISB: begin
                r = m + 8'd1; res.store_en = 1'b1; res.store_val = r;
                add_with_carry(~r, cin);
            end
            K_SLO: begin
                r = {m[6:0], 1'b0}; res.store_en = 1'b1; res.store_val = r;
                a_reg = a_reg | r; update_zn(a_reg);
                p_reg[FLAG_C] = m[7];
            end
            K_RLA: begin
                r = {m[6:0], cin}; res.store_en = 1'b1; res.store_val = r;
                a_reg = a_reg & r; update_zn(a_reg);
                p_reg[FLAG_C] = m[7];
            end
            K_SRE: begin
                r = {1'b0, m[7:1]}; res.store_en = 1'b1; res.store_val = r;
                a_reg = a_reg ^ r; update_zn(a_reg);
                p_reg[FLAG_C] = m[0];
            end
            K_RRA: begin
                r = {cin, m[7:1]}; res.store_en = 1'b1; res.store_val = r;
                add_with_carry(r, m[0]);
            end
            default: ;  // unused codes leave everything alone
        endcase
        res.acc = a_reg;
        res.x   = x_reg;
        res.y   = y_reg;
        res.sp  = sp_reg;
        res.p   = p_reg;
    endtask

    task automatic check_field(input string name, input logic [BYTE_W-1:0] want,
                               input logic [BYTE_W-1:0] got);
        if (got !== want) begin
            o_fail_count++;
            $error("%s: expected 0x%02h, got 0x%02h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        exec_result_t want;
        exec_result_t predicted;
        if (!i_rst_n) begin
            a_reg  = '0;
            x_reg  = '0;
            y_reg  = '0;
            sp_reg = SP_RESET;
            p_reg  = P_RESET;
            expected_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    o_fail_count++;
                    $error("result item with no expectation waiting");
                end else begin
                    want = expected_results.pop_front();
                    check_field("store_enable",  {7'b0, want.store_en}, {7'b0, i_m_tuser[0]});
                    check_field("store_value",   want.store_val, i_m_tdata[7:0]);
                    check_field("acc_out",       want.acc,       i_m_tdata[15:8]);
                    check_field("index_x_out",   want.x,         i_m_tdata[23:16]);
                    check_field("index_y_out",   want.y,         i_m_tdata[31:24]);
                    check_field("stack_ptr_out", want.sp,        i_m_tdata[39:32]);
                    check_field("status_out",    want.p,         i_m_tdata[47:40]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                execute_operation(i_s_tdata[5:0], i_s_tdata[13:6], i_s_tuser[0], predicted);
                expected_results.push_back(predicted);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench
// Drives decoded 6502 data operations into the execute unit under several
// idle and stall mixes and lets the checker compare every result item.
// ============================================================================
module testbench;
    import c6502eu_pkg::*;

    // codes past the last supported operation act as a no-op
    localparam logic [KIND_W-1:0] KIND_FIRST_UNUSED = 6'd46;
    localparam logic [KIND_W-1:0] KIND_LAST_UNUSED  = 6'd63;
    localparam int                PHASE_ITEMS       = 425;
    localparam int                LONG_HOLD_CYCLES  = 80;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_s_axis_tvalid;
    logic                 o_s_axis_tready;
    logic [S_TDATA_W-1:0] i_s_axis_tdata;   // [5:0] kind, [13:6] operand_value, [15:14] zero
    logic [S_TUSER_W-1:0] i_s_axis_tuser;   // [0] to_accumulator
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready;
    logic [M_TDATA_W-1:0] o_m_axis_tdata;   // [7:0] store_value, [15:8] acc_out,
                                            // [23:16] index_x_out, [31:24] index_y_out,
                                            // [39:32] stack_ptr_out, [47:40] status_out
    logic [M_TUSER_W-1:0] o_m_axis_tuser;   // [0] store_enable

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_req_cnt;
    int hold_ack_cnt;
    int hold_left;

    cpu6502_execute_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    cpu6502_execute_unit_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_axis_tvalid),
        .i_s_tready   (o_s_axis_tready),
        .i_s_tdata    (i_s_axis_tdata),
        .i_s_tuser    (i_s_axis_tuser),
        .i_m_tvalid   (o_m_axis_tvalid),
        .i_m_tready   (i_m_axis_tready),
        .i_m_tdata    (o_m_axis_tdata),
        .i_m_tuser    (o_m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // free-running 100 MHz clock
    always #5 i_clk = ~i_clk;

    // Receiver: stall at the phase's rate, or hold off completely for a long
    // stretch when the stimulus asks, so the unit backs up into its input.
    always @(negedge i_clk) begin
        if (hold_req_cnt != hold_ack_cnt) begin
            hold_ack_cnt = hold_req_cnt;
            hold_left    = LONG_HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one item: idle for a random number of cycles, then hold it until
    // the unit takes it. Called and returning at a falling edge.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [BYTE_W-1:0] operand,
                             input logic to_acc);
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, operand, kind};
        i_s_axis_tuser  <= to_acc;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
    endtask

    // Pause the sender until every predicted result has come back.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic run_random_phase(input int n_items, input int idle_pct, input int stall_pct,
                                    input bool_hold);
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] operand;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < n_items; i++) begin
            // hold the receiver off early in the phase while items keep coming
            if (bool_hold && i == 40) hold_req_cnt++;
            if ($urandom_range(99) < 5)
                kind = KIND_W'($urandom_range(KIND_LAST_UNUSED, KIND_FIRST_UNUSED));
            else
                kind = KIND_W'($urandom_range(K_RRA, K_ADC));
            // lean on the byte extremes now and then
            if ($urandom_range(7) == 0) begin
                case ($urandom_range(4))
                    0: operand = 8'h00;
                    1: operand = 8'h01;
                    2: operand = 8'h7F;
                    3: operand = 8'h80;
                    default: operand = 8'hFF;
                endcase
            end else begin
                operand = BYTE_W'($urandom_range(255));
            end
            send_item(kind, operand, 1'($urandom_range(1)));
        end
        drain_results();
    endtask

    initial begin
        i_clk           = 1'b0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = '0;
        i_m_axis_tready = 1'b0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_req_cnt    = 0;
        hold_ack_cnt    = 0;
        hold_left       = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: byte extremes, carry and overflow, accumulator vs memory
        // shifts, wraps, compares at the edges, transfers and the combined ops
        send_item(K_LDA, 8'h00, 1'b0);
        send_item(K_LDA, 8'h80, 1'b0);
        send_item(K_ADC, 8'hFF, 1'b0);
        send_item(K_SBC, 8'h7F, 1'b0);
        send_item(K_ASL, 8'h00, 1'b1);
        send_item(K_ROR, 8'hFF, 1'b0);
        send_item(K_LSR, 8'h01, 1'b1);
        send_item(K_ROL, 8'h80, 1'b0);
        send_item(K_INC, 8'hFF, 1'b1);
        send_item(K_DEC, 8'h00, 1'b0);
        send_item(K_LDX, 8'hFF, 1'b0);
        send_item(K_INX, 8'h00, 1'b0);
        send_item(K_DEY, 8'hFF, 1'b1);
        send_item(K_CMP, 8'h00, 1'b0);
        send_item(K_CPX, 8'hFF, 1'b0);
        send_item(K_BIT, 8'hC0, 1'b0);
        send_item(K_TSX, 8'h00, 1'b0);
        send_item(K_TXS, 8'h00, 1'b0);
        send_item(K_SAX, 8'h00, 1'b0);
        send_item(K_SED, 8'h00, 1'b0);
        send_item(K_SEI, 8'h00, 1'b0);
        send_item(K_DCP, 8'h00, 1'b0);
        send_item(K_ISB, 8'hFF, 1'b0);
        send_item(K_RRA, 8'h01, 1'b1);
        send_item(KIND_LAST_UNUSED, 8'hFF, 1'b1);
        drain_results();

        // random phases: no idling, sender gaps, receiver stalls, both light
        run_random_phase(PHASE_ITEMS, 0, 0, 1'b1);
        run_random_phase(PHASE_ITEMS, 48, 0, 1'b0);
        run_random_phase(PHASE_ITEMS, 0, 48, 1'b1);
        run_random_phase(PHASE_ITEMS, 8, 8, 1'b0);

        // let any straggling result show up before the verdict
        repeat (10) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/c6502eu_pkg.sv
src/cpu6502_execute_unit.sv
src/c6502eu_checker.sv
verif/cpu6502_execute_unit_checker.sv
verif/testbench.sv
